[src/mi3_pkg.sv]
// shared types and constants for the 3x3 matrix inverse and determinant pipeline
`default_nettype none
package mi3_pkg;

    localparam int ENTRY_W   = 16;
    localparam int FRAC_W    = 8;
    localparam int RES_W     = 32;
    localparam int PROD_W    = 2 * ENTRY_W;
    localparam int COF_W     = PROD_W + 1;
    localparam int DET_W     = 3 * ENTRY_W + 1;
    localparam int DMAG_W    = DET_W - 1;
    localparam int SHIFT     = FRAC_W + RES_W / 2;
    localparam int REM_W     = PROD_W + SHIFT;
    localparam int QUO_W     = RES_W + 2;
    localparam int TRIAL_W   = DMAG_W + QUO_W - 1;
    localparam int N_ENT     = 9;
    localparam int N_PROD    = 18;
    localparam int FRONT_LAT = 5;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [COF_W-1:0]   cof_t;
    typedef logic signed [DET_W-1:0]   det_t;
    typedef logic [DMAG_W-1:0]         dmag_t;
    typedef logic [REM_W-1:0]          rem_t;
    typedef logic [QUO_W-1:0]          quo_t;
    typedef logic [RES_W-1:0]          res_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_SINGULAR = 2'd1,
        STATUS_SAT      = 2'd2
    } status_t;

    typedef struct packed {
        rem_t rem;
        quo_t quo;
        logic neg;
    } lane_t;

    typedef struct packed {
        det_t  det;
        dmag_t dmag;
        logic  sing;
    } side_t;

    // adjugate entry i = a[MUL_A[2i]]*a[MUL_B[2i]] - a[MUL_A[2i+1]]*a[MUL_B[2i+1]]
    localparam int MUL_A [N_PROD] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
    localparam int MUL_B [N_PROD] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

endpackage
`default_nettype wire

[src/matrix3_inverse_determinant.sv]
// top level: 3x3 matrix inverse and determinant pipeline
// One matrix enters per transfer on the s_ channel: nine signed Q8.8 entries.
// One result leaves per transfer on the m_ channel: nine Q16.16 inverse
// entries (saturated), the exact Q25.24 determinant and a status code
// (0 ok, 1 singular with an all-zero inverse, 2 some entry saturated).
// From input transfer to m_valid an item passes the front stages (products,
// adjugate and determinant), the bit-per-stage divider and the saturation
// into the output register; every stage holds its own item.
// Throughput is one matrix per cycle while no m_ready stall holds the pipeline.
// The whole pipeline advances together, so when the receiver holds m_ready
// low with a result waiting, s_ready drops in the same cycle and every
// stage holds; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; the pipeline is
// empty and s_ready is high right after reset.
`default_nettype none
module matrix3_inverse_determinant
    import mi3_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_a_r0c0,
    input  wire logic [15:0] s_a_r0c1,
    input  wire logic [15:0] s_a_r0c2,
    input  wire logic [15:0] s_a_r1c0,
    input  wire logic [15:0] s_a_r1c1,
    input  wire logic [15:0] s_a_r1c2,
    input  wire logic [15:0] s_a_r2c0,
    input  wire logic [15:0] s_a_r2c1,
    input  wire logic [15:0] s_a_r2c2,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_inv_r0c0,
    output logic [31:0]      m_inv_r0c1,
    output logic [31:0]      m_inv_r0c2,
    output logic [31:0]      m_inv_r1c0,
    output logic [31:0]      m_inv_r1c1,
    output logic [31:0]      m_inv_r1c2,
    output logic [31:0]      m_inv_r2c0,
    output logic [31:0]      m_inv_r2c1,
    output logic [31:0]      m_inv_r2c2,
    output logic [48:0]      m_det_value,
    output logic [1:0]       m_status
);

    logic    en;
    entry_t  a [N_ENT];
    logic    f_valid;
    lane_t   f_lane [N_ENT];
    side_t   f_side;
    logic    d_valid;
    lane_t   d_lane [N_ENT];
    side_t   d_side;
    res_t    inv [N_ENT];
    det_t    det;
    status_t status;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    assign a[0] = s_a_r0c0;
    assign a[1] = s_a_r0c1;
    assign a[2] = s_a_r0c2;
    assign a[3] = s_a_r1c0;
    assign a[4] = s_a_r1c1;
    assign a[5] = s_a_r1c2;
    assign a[6] = s_a_r2c0;
    assign a[7] = s_a_r2c1;
    assign a[8] = s_a_r2c2;

    mi3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .a         (a),
        .out_valid (f_valid),
        .out_lane  (f_lane),
        .out_side  (f_side)
    );

    mi3_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_lane   (f_lane),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_lane  (d_lane),
        .out_side  (d_side)
    );

    mi3_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (d_valid),
        .in_lane    (d_lane),
        .in_side    (d_side),
        .out_valid  (m_valid),
        .out_inv    (inv),
        .out_det    (det),
        .out_status (status)
    );

    assign m_inv_r0c0  = inv[0];
    assign m_inv_r0c1  = inv[1];
    assign m_inv_r0c2  = inv[2];
    assign m_inv_r1c0  = inv[3];
    assign m_inv_r1c1  = inv[4];
    assign m_inv_r1c2  = inv[5];
    assign m_inv_r2c0  = inv[6];
    assign m_inv_r2c1  = inv[7];
    assign m_inv_r2c2  = inv[8];
    assign m_det_value = det;
    assign m_status    = status;

endmodule
`default_nettype wire

[src/mi3_front.sv]
// front pipeline: products, adjugate, determinant and magnitudes
`default_nettype none
module mi3_front
    import mi3_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire entry_t a [N_ENT],
    output logic        out_valid,
    output lane_t       out_lane [N_ENT],
    output side_t       out_side
);

    logic [FRONT_LAT-1:0] vld_reg;
    prod_t  prod_reg [N_PROD];
    entry_t row1_reg [3];
    cof_t   adj2_reg [N_ENT];
    entry_t row2_reg [3];
    cof_t   adj3_reg [N_ENT];
    det_t   dp_reg   [3];
    cof_t   adj4_reg [N_ENT];
    det_t   det_reg;
    lane_t  lane_reg [N_ENT];
    side_t  side_reg;

    prod_t  prod_next [N_PROD];
    cof_t   adj_next  [N_ENT];
    det_t   dp_next   [3];
    det_t   det_next;
    lane_t  lane_next [N_ENT];
    side_t  side_next;
    cof_t   cabs;
    det_t   dabs;

    always_comb begin
        for (int j = 0; j < N_PROD; j++) begin
            prod_next[j] = a[4'(MUL_A[j])] * a[4'(MUL_B[j])];
        end
        for (int i = 0; i < N_ENT; i++) begin
            adj_next[i] = COF_W'(prod_reg[2*i]) - COF_W'(prod_reg[2*i+1]);
        end
        dp_next[0] = row2_reg[0] * adj2_reg[0];
        dp_next[1] = row2_reg[1] * adj2_reg[3];
        dp_next[2] = row2_reg[2] * adj2_reg[6];
        det_next   = dp_reg[0] + dp_reg[1] + dp_reg[2];
        dabs = det_reg[DET_W-1] ? -det_reg : det_reg;
        side_next.det  = det_reg;
        side_next.dmag = dabs[DMAG_W-1:0];
        side_next.sing = (det_reg == '0);
        for (int i = 0; i < N_ENT; i++) begin
            cabs = adj4_reg[i][COF_W-1] ? -adj4_reg[i] : adj4_reg[i];
            lane_next[i].rem = {cabs[PROD_W-1:0], SHIFT'(0)};
            lane_next[i].quo = '0;
            lane_next[i].neg = adj4_reg[i][COF_W-1] ^ det_reg[DET_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[FRONT_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            row1_reg <= '{a[0], a[1], a[2]};
            adj2_reg <= adj_next;
            row2_reg <= row1_reg;
            adj3_reg <= adj2_reg;
            dp_reg   <= dp_next;
            adj4_reg <= adj3_reg;
            det_reg  <= det_next;
            lane_reg <= lane_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[FRONT_LAT-1];
    assign out_lane  = lane_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

[src/mi3_divider.sv]
// restoring divider pipeline, one quotient bit per stage for all nine lanes
`default_nettype none
module mi3_divider
    import mi3_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire lane_t in_lane [N_ENT],
    input  wire side_t in_side,
    output logic       out_valid,
    output lane_t      out_lane [N_ENT],
    output side_t      out_side
);

    logic  vld_reg  [QUO_W];
    lane_t lane_reg [QUO_W][N_ENT];
    side_t side_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int K = QUO_W - 1 - s;
        logic  vld_prev;
        lane_t lane_prev [N_ENT];
        side_t side_prev;
        lane_t lane_next [N_ENT];
        logic [TRIAL_W-1:0] trial;
        logic [TRIAL_W-1:0] wide_rem;
        logic               ge;

        if (s == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign lane_prev = in_lane;
            assign side_prev = in_side;
        end else begin : g_rest
            assign vld_prev  = vld_reg[s-1];
            assign lane_prev = lane_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        always_comb begin
            trial = TRIAL_W'(side_prev.dmag) << K;
            for (int i = 0; i < N_ENT; i++) begin
                wide_rem = TRIAL_W'(lane_prev[i].rem);
                ge = (wide_rem >= trial);
                lane_next[i].rem = ge ? REM_W'(wide_rem - trial) : lane_prev[i].rem;
                lane_next[i].quo = {lane_prev[i].quo[QUO_W-2:0], ge};
                lane_next[i].neg = lane_prev[i].neg;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lane_reg[s] <= lane_next;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign out_lane  = lane_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule
`default_nettype wire

[src/mi3_back.sv]
// sign, saturation and status, with the output register
`default_nettype none
module mi3_back
    import mi3_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire logic  in_valid,
    input  wire lane_t in_lane [N_ENT],
    input  wire side_t in_side,
    output logic       out_valid,
    output res_t       out_inv [N_ENT],
    output det_t       out_det,
    output status_t    out_status
);

    logic    vld_reg;
    res_t    inv_reg [N_ENT];
    det_t    det_reg;
    status_t status_reg;

    res_t    inv_next [N_ENT];
    status_t status_next;
    logic    any_sat;
    logic    sat;
    quo_t    q;

    always_comb begin
        any_sat = 1'b0;
        for (int i = 0; i < N_ENT; i++) begin
            q = in_lane[i].quo;
            if (in_lane[i].neg) begin
                sat = (q[QUO_W-1:RES_W] != '0) || (q[RES_W-1] && (q[RES_W-2:0] != '0));
                inv_next[i] = sat ? {1'b1, (RES_W-1)'(0)} : -q[RES_W-1:0];
            end else begin
                sat = (q[QUO_W-1:RES_W-1] != '0);
                inv_next[i] = sat ? {1'b0, {(RES_W-1){1'b1}}} : q[RES_W-1:0];
            end
            if (in_side.sing) begin
                inv_next[i] = '0;
            end
            any_sat = any_sat | sat;
        end
        priority if (in_side.sing) begin
            status_next = STATUS_SINGULAR;
        end else if (any_sat) begin
            status_next = STATUS_SAT;
        end else begin
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            inv_reg    <= inv_next;
            det_reg    <= in_side.det;
            status_reg <= status_next;
        end
    end

    assign out_valid  = vld_reg;
    assign out_inv    = inv_reg;
    assign out_det    = det_reg;
    assign out_status = status_reg;

endmodule
`default_nettype wire

[src/mi3_checker.sv]
// port checker for the matrix inverse pipeline, bound to the top level
`default_nettype none
module mi3_checker
    import mi3_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_inv_r0c0,
    input wire logic [31:0] m_inv_r2c2,
    input wire logic [48:0] m_det_value,
    input wire logic [1:0]  m_status
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_det_value) && $stable(m_status))
        else $error("stalled result changed");

    // the pipeline stalls only behind a waiting result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    a_sing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_SINGULAR |->
            m_det_value == '0 && m_inv_r0c0 == '0 && m_inv_r2c2 == '0)
        else $error("singular result not cleared");

    a_det: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_OK || m_status == STATUS_SAT) |-> m_det_value != '0)
        else $error("zero determinant not flagged singular");

endmodule

bind matrix3_inverse_determinant mi3_checker u_mi3_checker (.*);
`default_nettype wire

[tb/sv/testbench.sv]
// testbench for the 3x3 matrix inverse and determinant pipeline
`timescale 1ns / 100ps
module testbench
    import mi3_pkg::*;
();

    typedef struct {
        logic signed [15:0] a [9];
    } matrix_t;

    typedef struct {
        logic [31:0] inv [9];
        logic [48:0] det;
        status_t     st;
    } inverse_t;

    localparam int CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [15:0] s_a [9];
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] m_inv [9];
    logic [48:0] m_det_value;
    logic [1:0] m_status;

    inverse_t expected_inverses[$];
    int errors = 0;
    int cycles = 0;
    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;
    bit hold_off = 1'b0;

    initial begin
        for (int i = 0; i < 9; i++) s_a[i] = '0;
    end

    matrix3_inverse_determinant DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_r0c0(s_a[0]), .s_a_r0c1(s_a[1]), .s_a_r0c2(s_a[2]),
        .s_a_r1c0(s_a[3]), .s_a_r1c1(s_a[4]), .s_a_r1c2(s_a[5]),
        .s_a_r2c0(s_a[6]), .s_a_r2c1(s_a[7]), .s_a_r2c2(s_a[8]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_inv_r0c0(m_inv[0]), .m_inv_r0c1(m_inv[1]), .m_inv_r0c2(m_inv[2]),
        .m_inv_r1c0(m_inv[3]), .m_inv_r1c1(m_inv[4]), .m_inv_r1c2(m_inv[5]),
        .m_inv_r2c0(m_inv[6]), .m_inv_r2c1(m_inv[7]), .m_inv_r2c2(m_inv[8]),
        .m_det_value(m_det_value), .m_status(m_status)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] divide_saturate(logic signed [63:0] cof,
                                                    logic signed [63:0] det,
                                                    inout bit sat);
        logic signed [63:0] num;
        logic [63:0] q;
        bit neg;
        num = cof <<< 24;
        neg = num[63] != det[63];
        q = (num < 0 ? -num : num) / (det < 0 ? -det : det);
        if (!neg) begin
            if (q > 64'h7fff_ffff) begin
                q = 64'h7fff_ffff;
                sat = 1'b1;
            end
            return q[31:0];
        end
        if (q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            sat = 1'b1;
        end
        q = -q;
        return q[31:0];
    endfunction

    function automatic inverse_t invert_matrix(matrix_t m);
        logic signed [63:0] e [9];
        logic signed [63:0] adj [9];
        logic signed [63:0] det;
        inverse_t r;
        bit sat;
        sat = 1'b0;
        for (int i = 0; i < 9; i++) e[i] = m.a[i];
        adj[0] = e[4] * e[8] - e[5] * e[7];
        adj[1] = e[2] * e[7] - e[1] * e[8];
        adj[2] = e[1] * e[5] - e[2] * e[4];
        adj[3] = e[5] * e[6] - e[3] * e[8];
        adj[4] = e[0] * e[8] - e[2] * e[6];
        adj[5] = e[2] * e[3] - e[0] * e[5];
        adj[6] = e[3] * e[7] - e[4] * e[6];
        adj[7] = e[1] * e[6] - e[0] * e[7];
        adj[8] = e[0] * e[4] - e[1] * e[3];
        det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
        if (det == 0) begin
            for (int i = 0; i < 9; i++) r.inv[i] = '0;
            r.det = '0;
            r.st = STATUS_SINGULAR;
            return r;
        end
        for (int i = 0; i < 9; i++) r.inv[i] = divide_saturate(adj[i], det, sat);
        r.det = det[48:0];
        r.st = sat ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    task automatic send_matrix(matrix_t m);
        if (send_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        for (int i = 0; i < 9; i++) s_a[i] = m.a[i];
        s_valid <= 1'b1;
        expected_inverses.push_back(invert_matrix(m));
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // receiver side
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (200) @(negedge aclk);
                hold_off = 1'b0;
                m_ready <= 1'b1;
            end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_inverses.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                inverse_t x;
                x = expected_inverses.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (m_inv[i] !== x.inv[i]) begin
                        $error("inv[%0d] expected %h actual %h", i, x.inv[i], m_inv[i]);
                        errors++;
                    end
                end
                if (m_det_value !== x.det) begin
                    $error("det_value expected %h actual %h", x.det, m_det_value);
                    errors++;
                end
                if (m_status !== x.st) begin
                    $error("status expected %0d actual %0d", x.st, m_status);
                    errors++;
                end
            end
        end
    end

    function automatic matrix_t random_matrix();
        matrix_t m;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            case (kind)
                0: m.a[i] = 16'($urandom);
                1: m.a[i] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                2, 3: m.a[i] = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
                default: m.a[i] = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
            endcase
        end
        // sometimes make it singular by repeating a row
        if ($urandom_range(0, 9) == 0) begin
            for (int j = 0; j < 3; j++) m.a[6 + j] = m.a[j];
        end
        // sometimes a scaled identity with tiny entries, which has a large inverse
        if ($urandom_range(0, 19) == 0) begin
            for (int i = 0; i < 9; i++) m.a[i] = '0;
            m.a[0] = 16'($urandom_range(1, 3));
            m.a[4] = 16'($urandom_range(1, 3));
            m.a[8] = 16'($urandom_range(1, 3));
        end
        return m;
    endfunction

    task automatic test_directed();
        matrix_t m;
        for (int i = 0; i < 9; i++) m.a[i] = '0;
        send_matrix(m);
        m.a[0] = 16'sh0100; m.a[4] = 16'sh0100; m.a[8] = 16'sh0100;
        send_matrix(m);
        m.a[0] = 16'sh7fff; m.a[4] = 16'sh7fff; m.a[8] = 16'sh7fff;
        send_matrix(m);
        m.a[0] = 16'sh8000; m.a[4] = 16'sh8000; m.a[8] = 16'sh8000;
        send_matrix(m);
        m.a[0] = 16'sh0001; m.a[4] = 16'sh0001; m.a[8] = 16'sh0001;
        send_matrix(m);
        m.a[0] = 16'shffff; m.a[4] = 16'sh0001; m.a[8] = 16'sh0001;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m.a[i] = 16'sh7fff;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m.a[i] = (i % 2) ? 16'sh8000 : 16'sh7fff;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m.a[i] = '0;
        m.a[2] = 16'sh8000; m.a[4] = 16'sh8000; m.a[6] = 16'sh8000;
        send_matrix(m);
        m.a[2] = 16'sh7fff; m.a[4] = 16'sh7fff; m.a[6] = 16'sh8000;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m.a[i] = 16'(i * 37 + 5);
        m.a[8] = 16'sh0200;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m.a[i] = ~16'(i * 37 + 5);
        send_matrix(m);
    endtask

    task automatic test_back_pressure();
        hold_off = 1'b1;
        for (int n = 0; n < 80; n++) send_matrix(random_matrix());
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_matrix(random_matrix());
    endtask

    task automatic test_full_rate(int count);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        for (int n = 0; n < count; n++) send_matrix(random_matrix());
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_back_pressure();
        test_random(1000);
        test_full_rate(250);
        s_valid <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
